/* sv/sat_pkg.sv */
// ---------------------------------------------------------------------------
// sat_pkg: shared types and codes for the sorted array table
// Request kinds, result status codes and the command bus to the cell row.
// ---------------------------------------------------------------------------
package sat_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_RSVD = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_CMP  = 2'd1,
        CMD_INS  = 2'd2,
        CMD_REM  = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                  cmd;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

    typedef struct packed {
        logic exhausted;
        logic hit;
    } probe_stat_t;

endpackage

/* sv/sorted_array_table.sv */
// ---------------------------------------------------------------------------
// sorted_array_table: ordered table of signed 32-bit values
// A row of cells keeps up to DEPTH values in ascending order; requests
// insert, search or remove one value and return one status transfer.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per transfer (op, value). m_ channel
//   returns exactly one result per request (status, position, count).
//   Insert: accept, one shift of the row (APPLY), then the result register.
//   Search and remove: the cells register their compare flags in one pass
//   (CMP), then binary search probes run one per cycle over those flags
//   (PROBE); a remove that hits then shifts the row (APPLY) before RESP.
//   Full insert and unused op codes go straight from accept to RESP.
//   One request is in work at a time; the next one is accepted once the
//   current result sits in the output register, even if the receiver has
//   not taken it yet. A stalled receiver holds the result and, once the next
//   request reaches RESP, holds off further requests.
//   Reset empties the table (count 0) and drops any pending result; the
//   stored cell values need no clearing, since only entries below the
//   count are ever read.
// ---------------------------------------------------------------------------
module sorted_array_table #(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] op, [33:2] value, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [7:2] position, [14:8] count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CMP   = 5'b00010,
        ST_PROBE = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t                              state_reg, state_next;
    sat_pkg::op_t                        op_reg, op_next;
    logic signed [sat_pkg::VALUE_W-1:0]  value_reg, value_next;
    sat_pkg::status_t                    status_reg, status_next;
    logic [AW-1:0]                       pos_reg, pos_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [15:0]                         m_tdata_reg, m_tdata_next;

    sat_pkg::cell_ctl_t                  ctl;
    sat_pkg::probe_stat_t                pstat;
    logic [AW-1:0]                       mid;
    logic                                s_xfer;
    logic                                out_free;

    logic signed [sat_pkg::VALUE_W-1:0]  entry_vec [DEPTH];
    logic [DEPTH-1:0]                    gt_vec;
    logic [DEPTH-1:0]                    eq_vec;
    logic [DEPTH-1:0]                    lt_vec;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        ctl.value = value_reg;
        case (state_reg)
            ST_CMP:   ctl.cmd = sat_pkg::CMD_CMP;
            ST_APPLY: ctl.cmd = (op_reg == sat_pkg::OP_INSERT) ? sat_pkg::CMD_INS
                                                               : sat_pkg::CMD_REM;
            default:  ctl.cmd = sat_pkg::CMD_HOLD;
        endcase
    end

    // cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [sat_pkg::VALUE_W-1:0] prev_entry;
        logic signed [sat_pkg::VALUE_W-1:0] next_entry;
        logic                               prev_gt;

        if (i == 0) begin : g_first
            assign prev_entry = entry_vec[i];
            assign prev_gt    = 1'b0;
        end else begin : g_mid
            assign prev_entry = entry_vec[i-1];
            assign prev_gt    = gt_vec[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_entry = entry_vec[i];
        end else begin : g_inner
            assign next_entry = entry_vec[i+1];
        end

        sat_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .valid_in   (CW'(i) < count_reg),
            .at_fill    (CW'(i) == count_reg),
            .shift_here (AW'(i) >= pos_reg),
            .prev_entry (prev_entry),
            .prev_gt    (prev_gt),
            .next_entry (next_entry),
            .entry      (entry_vec[i]),
            .gt         (gt_vec[i]),
            .eq_flag    (eq_vec[i]),
            .lt_flag    (lt_vec[i])
        );
    end

    sat_search #(
        .DEPTH (DEPTH)
    ) u_search (
        .aclk   (aclk),
        .start  (state_reg == ST_CMP),
        .step   (state_reg == ST_PROBE),
        .count  (count_reg),
        .eq_vec (eq_vec),
        .lt_vec (lt_vec),
        .stat   (pstat),
        .mid    (mid)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    op_next     = sat_pkg::op_t'(s_tdata[1:0]);
                    value_next  = s_tdata[33:2];
                    status_next = sat_pkg::STAT_MISS;
                    pos_next    = '0;
                    case (sat_pkg::op_t'(s_tdata[1:0]))
                        sat_pkg::OP_INSERT: begin
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = sat_pkg::STAT_FULL;
                                state_next  = ST_RESP;
                            end else begin
                                state_next  = ST_APPLY;
                            end
                        end
                        sat_pkg::OP_SEARCH,
                        sat_pkg::OP_REMOVE: state_next = ST_CMP;
                        default:            state_next = ST_RESP;
                    endcase
                end
            end
            ST_CMP: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (pstat.exhausted) begin
                    state_next = ST_RESP;
                end else if (pstat.hit) begin
                    pos_next    = mid;
                    status_next = sat_pkg::STAT_OK;
                    state_next  = (op_reg == sat_pkg::OP_REMOVE) ? ST_APPLY : ST_RESP;
                end
            end
            ST_APPLY: begin
                status_next = sat_pkg::STAT_OK;
                count_next  = (op_reg == sat_pkg::OP_INSERT) ? count_reg + CW'(1)
                                                             : count_reg - CW'(1);
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, sat_pkg::COUNT_W'(count_reg),
                                     sat_pkg::POS_W'(pos_reg), status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/sat_cell.sv */
// ---------------------------------------------------------------------------
// sat_cell: one entry of the sorted table
// Holds one value, compares it against the request value and shifts toward
// its neighbors on insert and remove.
// ---------------------------------------------------------------------------
module sat_cell (
    input  logic                                aclk,
    input  sat_pkg::cell_ctl_t                  ctl,
    input  logic                                valid_in,
    input  logic                                at_fill,
    input  logic                                shift_here,
    input  logic signed [sat_pkg::VALUE_W-1:0]  prev_entry,
    input  logic                                prev_gt,
    input  logic signed [sat_pkg::VALUE_W-1:0]  next_entry,
    output logic signed [sat_pkg::VALUE_W-1:0]  entry,
    output logic                                gt,
    output logic                                eq_flag,
    output logic                                lt_flag
);

    logic signed [sat_pkg::VALUE_W-1:0] entry_reg;
    logic signed [sat_pkg::VALUE_W-1:0] entry_next;
    logic                               eq_reg;
    logic                               lt_reg;

    // stored entry is larger than the request value
    assign gt = valid_in && (ctl.value < entry_reg);

    always_comb begin
        entry_next = entry_reg;
        case (ctl.cmd)
            sat_pkg::CMD_INS: begin
                if (gt || at_fill) begin
                    entry_next = prev_gt ? prev_entry : ctl.value;
                end
            end
            sat_pkg::CMD_REM: begin
                if (shift_here) begin
                    entry_next = next_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctl.cmd == sat_pkg::CMD_CMP) begin
            eq_reg <= (entry_reg == ctl.value);
            lt_reg <= (entry_reg < ctl.value);
        end
    end

    assign entry   = entry_reg;
    assign eq_flag = eq_reg;
    assign lt_flag = lt_reg;

endmodule

/* sv/sat_search.sv */
// ---------------------------------------------------------------------------
// sat_search: binary search probe unit
// Walks the lower and upper bounds over the registered compare flags of the
// cell row, one probe per cycle while step is high.
// ---------------------------------------------------------------------------
module sat_search #(
    parameter int DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        start,
    input  logic                        step,
    input  logic [$clog2(DEPTH+1)-1:0]  count,
    input  logic [DEPTH-1:0]            eq_vec,
    input  logic [DEPTH-1:0]            lt_vec,
    output sat_pkg::probe_stat_t        stat,
    output logic [$clog2(DEPTH)-1:0]    mid
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic signed [CW:0] lo_reg;
    logic signed [CW:0] lo_next;
    logic signed [CW:0] hi_reg;
    logic signed [CW:0] hi_next;
    logic [CW:0]        sum;
    logic [CW-1:0]      mid_full;

    // both bounds are nonnegative whenever a probe is live
    assign sum      = {1'b0, lo_reg[CW-1:0]} + {1'b0, hi_reg[CW-1:0]};
    assign mid_full = sum[CW:1];
    assign mid      = mid_full[AW-1:0];

    assign stat.exhausted = lo_reg > hi_reg;
    assign stat.hit       = !stat.exhausted && eq_vec[mid];

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (start) begin
            lo_next = '0;
            hi_next = $signed({1'b0, count}) - (CW+1)'(1);
        end else if (step && !stat.exhausted && !stat.hit) begin
            if (lt_vec[mid]) begin
                lo_next = $signed({1'b0, mid_full}) + (CW+1)'(1);
            end else begin
                hi_next = $signed({1'b0, mid_full}) - (CW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule
